// File: hdl/sidcp_pkg.sv
// Shared types and constants for the security identifier check and pack unit.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none
package sidcp_pkg;

   localparam int TABLE_ROWS = 64;

   localparam int ID_WIDTH     = 64;
   localparam int PACKED_WIDTH = 30;
   localparam int ROW_WIDTH    = 6;
   localparam int DIGIT_WIDTH  = 6;
   localparam int NUM_DIGITS   = 5;

   // Row selection mask, cut to the width of the row index port.
   localparam logic [ROW_WIDTH-1:0] ROW_MASK = ROW_WIDTH'((TABLE_ROWS - 1) & 63);

   localparam logic [ID_WIDTH-1:0] NUM21_MASK  = 64'h0000_0000_001F_FFFF;
   localparam logic [ID_WIDTH-1:0] MASKED_MASK = 64'h0000_0000_3E00_FFFF;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UZ    = 8'h5A;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LZ    = 8'h7A;
   localparam logic [7:0] UPPER_BASE = 8'd10;
   localparam logic [7:0] LOWER_BASE = 8'd36;

   typedef enum logic [1:0] {
      FMT_NUM21  = 2'd0,
      FMT_MASKED = 2'd1,
      FMT_ALNUM  = 2'd2,
      FMT_NONE   = 2'd3
   } feed_format_type;

   typedef struct packed {
      logic                   ok;
      logic [DIGIT_WIDTH-1:0] digit;
   } digit_type;

   typedef struct packed {
      logic                    id_ok;
      logic [PACKED_WIDTH-1:0] packed_id;
      logic [ROW_WIDTH-1:0]    row_index;
   } result_type;

endpackage
`default_nettype wire

// File: hdl/sidcp_digit.sv
// Maps one symbol byte to its base-62 digit and flags whether it is alphanumeric.
// Depends on sidcp_pkg.
`default_nettype none
module sidcp_digit (
   input  wire logic [7:0]           sym_byte,
   output sidcp_pkg::digit_type      digit_out
);
   import sidcp_pkg::*;

   logic is_num;
   logic is_upper;
   logic is_lower;
   logic [7:0] value;

   always_comb begin
      is_num   = (sym_byte >= CHAR_ZERO) && (sym_byte <= CHAR_NINE);
      is_upper = (sym_byte >= CHAR_UA) && (sym_byte <= CHAR_UZ);
      is_lower = (sym_byte >= CHAR_LA) && (sym_byte <= CHAR_LZ);
      if (is_num) begin
         value = sym_byte - CHAR_ZERO;
      end else if (is_upper) begin
         value = sym_byte - CHAR_UA + UPPER_BASE;
      end else if (is_lower) begin
         value = sym_byte - CHAR_LA + LOWER_BASE;
      end else begin
         value = 8'd0;
      end
      digit_out.ok    = is_num || is_upper || is_lower;
      digit_out.digit = value[DIGIT_WIDTH-1:0];
   end

endmodule
`default_nettype wire

// File: hdl/sidcp_pack.sv
// Checks one identifier under the feed format and packs it into id and row index.
// Depends on sidcp_pkg and sidcp_digit.
`default_nettype none
module sidcp_pack (
   input  wire sidcp_pkg::feed_format_type     feed_format,
   input  wire logic [sidcp_pkg::ID_WIDTH-1:0] security_id,
   output sidcp_pkg::result_type                result
);
   import sidcp_pkg::*;

   digit_type               digits [NUM_DIGITS];
   logic [PACKED_WIDTH-1:0] alnum_packed;
   logic                    alnum_ok;
   logic                    ok;
   logic [PACKED_WIDTH-1:0] packed_val;

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
      sidcp_digit u_digit (
         .sym_byte  (security_id[8*k +: 8]),
         .digit_out (digits[k])
      );
      assign alnum_packed[DIGIT_WIDTH*k +: DIGIT_WIDTH] = digits[k].digit;
   end

   always_comb begin
      alnum_ok = (security_id[47:40] == CHAR_ZERO)
              && (security_id[39:32] >= CHAR_ZERO)
              && (security_id[39:32] <= CHAR_THREE)
              && digits[0].ok && digits[1].ok && digits[2].ok && digits[3].ok;

      unique case (feed_format)
         FMT_NUM21: begin
            ok         = (security_id & ~NUM21_MASK) == '0;
            packed_val = security_id[PACKED_WIDTH-1:0];
         end
         FMT_MASKED: begin
            ok         = (security_id & ~MASKED_MASK) == '0;
            packed_val = security_id[PACKED_WIDTH-1:0];
         end
         FMT_ALNUM: begin
            ok         = alnum_ok;
            packed_val = alnum_packed;
         end
         default: begin
            ok         = 1'b0;
            packed_val = '0;
         end
      endcase

      result.id_ok     = ok;
      result.packed_id = ok ? packed_val : '0;
      result.row_index = result.packed_id[ROW_WIDTH-1:0] & ROW_MASK;
   end

endmodule
`default_nettype wire

// File: hdl/security_id_check_and_pack_unit.sv
// Top level of the security identifier check and pack unit: input register,
// check and pack logic, result register. Depends on sidcp_pkg and sidcp_pack.
// An accepted beat passes the input register and then the result register before it shows on rsp_valid.
// Throughput is one beat per cycle; busy is never raised, as the check is a single pass.
// The receiver cannot stall, so each result shows for exactly one cycle on rsp_valid.
// Synchronous reset clears the stage flags and sets the feed format to numeric 21-bit.
`default_nettype none
module security_id_check_and_pack_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic [sidcp_pkg::ID_WIDTH-1:0]    req_security_id,
   input  wire logic                              csr_wr_en,
   input  wire logic [1:0]                        csr_wr_data,
   output      logic                              rsp_valid,
   output      logic                              rsp_id_ok,
   output      logic [sidcp_pkg::PACKED_WIDTH-1:0] rsp_packed_id,
   output      logic [sidcp_pkg::ROW_WIDTH-1:0]   rsp_row_index
);
   import sidcp_pkg::*;

   // The feed format register. The user must write it only while the unit is idle; the block
   // does not enforce this. So the pack stage may read it directly for the beat it holds.
   feed_format_type format_ff;
   feed_format_type format_in;

   // Input register: holds the accepted beat for the check and pack logic.
   logic                 req_valid_ff;
   logic                 req_valid_in;
   logic [ID_WIDTH-1:0]  req_id_ff;
   logic [ID_WIDTH-1:0]  req_id_in;

   // Result register driving the response ports.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;
   result_type pack_result;

   logic accept;

   // Every cycle can take a beat, so busy stays low.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      format_in    = csr_wr_en ? feed_format_type'(csr_wr_data) : format_ff;
      req_valid_in = accept;
      req_id_in    = accept ? req_security_id : req_id_ff;
      rsp_valid_in = req_valid_ff;
      rsp_in       = req_valid_ff ? pack_result : rsp_ff;
   end

   sidcp_pack u_pack (
      .feed_format (format_ff),
      .security_id (req_id_ff),
      .result      (pack_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_NUM21;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      req_id_ff <= req_id_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_id_ok     = rsp_ff.id_ok;
   assign rsp_packed_id = rsp_ff.packed_id;
   assign rsp_row_index = rsp_ff.row_index;

   // Every accepted beat comes out on rsp_valid after the input and result registers.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted beat did not produce a result two cycles later");

   // A failed check must deliver zero id and row.
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_id_ok) |-> (rsp_packed_id == '0 && rsp_row_index == '0))
      else $error("failed check delivered a nonzero id or row");

   // The row index always follows the low bits of the packed id.
   a_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_index == (rsp_packed_id[ROW_WIDTH-1:0] & ROW_MASK)))
      else $error("row index does not match packed id");

   // Under the unsupported format nothing passes the check.
   a_unsupported : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && format_ff == FMT_NONE) |-> !rsp_id_ok)
      else $error("unsupported format passed an identifier");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the security identifier check and pack unit.
// Depends on sidcp_pkg and security_id_check_and_pack_unit from hdl; no other files.
// Drives identifiers under every feed format and checks each result beat.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sidcp_pkg::*;

   // Nothing can be accepted during a sender gap, nor during the drain, the latency pause and
   // the write around a feed format change. This limit allows many times the longest such span.
   localparam int WATCHDOG_LIMIT = 200;
   localparam int PHASE_BEATS    = 50;
   localparam int MAX_PRINTED    = 40;

   // Scoreboard: predicts the result of each accepted identifier under the current feed
   // format, and compares every result beat with the oldest prediction.
   class id_pack_scoreboard;
      feed_format_type fmt;
      result_type      pending_results[$];
      int              error_count;
      int              checked_count;
      int              passed_count;

      function new();
         fmt           = FMT_NUM21;
         error_count   = 0;
         checked_count = 0;
         passed_count  = 0;
      endfunction

      function automatic bit is_symbol_char(logic [7:0] c);
         return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UA && c <= CHAR_UZ) ||
                (c >= CHAR_LA && c <= CHAR_LZ);
      endfunction

      function automatic logic [DIGIT_WIDTH-1:0] base62_digit(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return DIGIT_WIDTH'(c - CHAR_ZERO);
         end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
            return DIGIT_WIDTH'(c - CHAR_UA + UPPER_BASE);
         end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
            return DIGIT_WIDTH'(c - CHAR_LA + LOWER_BASE);
         end
         return '0;
      endfunction

      function automatic result_type check_and_pack(logic [ID_WIDTH-1:0] id);
         result_type          res;
         logic                ok;
         logic [ID_WIDTH-1:0] acc;
         ok  = 1'b0;
         acc = '0;
         case (fmt)
            FMT_NUM21: begin
               ok  = (id & ~NUM21_MASK) == '0;
               acc = id;
            end
            FMT_MASKED: begin
               ok  = (id & ~MASKED_MASK) == '0;
               acc = id;
            end
            FMT_ALNUM: begin
               ok = id[47:40] == CHAR_ZERO && id[39:32] >= CHAR_ZERO && id[39:32] <= CHAR_THREE;
               for (int k = 0; k < 4; k++)
                  if (!is_symbol_char(id[8*k +: 8])) ok = 1'b0;
               for (int k = 0; k < NUM_DIGITS; k++)
                  acc[DIGIT_WIDTH*k +: DIGIT_WIDTH] = base62_digit(id[8*k +: 8]);
            end
            default: ok = 1'b0;
         endcase
         if (!ok) acc = '0;
         res.id_ok     = ok;
         res.packed_id = acc[PACKED_WIDTH-1:0];
         res.row_index = acc[ROW_WIDTH-1:0] & ROW_MASK;
         return res;
      endfunction

      task report_mismatch(string what);
         error_count++;
         if (error_count <= MAX_PRINTED)
            $display("%0t ns: MISMATCH %s", $time, what);
      endtask

      function void note_request(logic [ID_WIDTH-1:0] id);
         pending_results.push_back(check_and_pack(id));
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      task check_result(logic ok, logic [PACKED_WIDTH-1:0] pid, logic [ROW_WIDTH-1:0] row);
         result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no identifier outstanding");
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (want.id_ok) passed_count++;
            if (ok !== want.id_ok)
               report_mismatch($sformatf("id_ok: got %b, expected %b", ok, want.id_ok));
            if (pid !== want.packed_id)
               report_mismatch($sformatf("packed_id: got %h, expected %h", pid, want.packed_id));
            if (row !== want.row_index)
               report_mismatch($sformatf("row_index: got %h, expected %h", row, want.row_index));
         end
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ID_WIDTH-1:0]     req_security_id;
   logic                    csr_wr_en;
   logic [1:0]              csr_wr_data;
   logic                    rsp_valid;
   logic                    rsp_id_ok;
   logic [PACKED_WIDTH-1:0] rsp_packed_id;
   logic [ROW_WIDTH-1:0]    rsp_row_index;

   id_pack_scoreboard sb = new();
   int idle_cycles   = 0;
   int beats_per_fmt[4] = '{0, 0, 0, 0};
   int directed_beats = 0;
   int format_writes  = 0;

   security_id_check_and_pack_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_security_id (req_security_id),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_id_ok       (rsp_id_ok),
      .rsp_packed_id   (rsp_packed_id),
      .rsp_row_index   (rsp_row_index)
   );

   // 12 ns clock, low half first.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Result side: the receiver cannot hold results off, so every strobe is a beat and is
   // checked at the rising edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result(rsp_id_ok, rsp_packed_id, rsp_row_index);
   end

   // Watchdog: counts cycles in which neither side moves a beat. A hung block ends the run.
   always @(posedge clock) begin
      if (!reset && ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog expired with %0d results outstanding", $time,
                  sb.outstanding());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [ID_WIDTH-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] random_symbol_char();
      int idx;
      idx = $urandom_range(0, 61);
      if (idx < 10) return CHAR_ZERO + 8'(idx);
      if (idx < 36) return CHAR_UA + 8'(idx - 10);
      return CHAR_LA + 8'(idx - 36);
   endfunction

   // A well-formed symbol: prefix '0' then '0'..'3', four alphanumerics, and whatever
   // happens to sit in the two unexamined top bytes.
   function automatic logic [ID_WIDTH-1:0] random_symbol();
      logic [ID_WIDTH-1:0] id;
      id = rand64();
      id[47:40] = CHAR_ZERO;
      id[39:32] = CHAR_ZERO + 8'($urandom_range(0, 3));
      for (int k = 0; k < 4; k++)
         id[8*k +: 8] = random_symbol_char();
      return id;
   endfunction

   // Random identifier shaped for the current feed format: mostly ids that fit it, then ids
   // with one random bit set or one byte overwritten at random, and some plain noise.
   function automatic logic [ID_WIDTH-1:0] random_id(feed_format_type f);
      logic [ID_WIDTH-1:0] id;
      int                  r;
      r  = $urandom_range(0, 99);
      id = rand64();
      if (r >= 85) return id;
      case (f)
         FMT_NUM21: begin
            if (r < 60) id &= NUM21_MASK;
            else id = (id & NUM21_MASK) | (64'd1 << $urandom_range(21, 63));
         end
         FMT_MASKED: begin
            if (r < 60) id &= MASKED_MASK;
            else id = (id & MASKED_MASK) | (64'd1 << $urandom_range(0, 63));
         end
         FMT_ALNUM: begin
            id = random_symbol();
            if (r >= 65) id[8*$urandom_range(0, 5) +: 8] = 8'($urandom_range(0, 255));
         end
         default: begin
            if (r < 45) id = random_symbol();
         end
      endcase
      return id;
   endfunction

   // Offers one identifier after a number of idle cycles and returns at the accepting edge.
   // Start stays high when the next beat follows with no gap.
   task automatic send_id(logic [ID_WIDTH-1:0] id, int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_security_id <= id;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(id);
      beats_per_fmt[sb.fmt]++;
   endtask

   // Changes the feed format only once the block is idle: start is dropped, every
   // outstanding result has to come back, and then the latency is allowed to pass.
   task automatic set_feed_format(feed_format_type f);
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= f;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.fmt = f;
      format_writes++;
   endtask

   task automatic send_directed(logic [ID_WIDTH-1:0] id);
      send_id(id, $urandom_range(0, 3));
      directed_beats++;
   endtask

   initial begin
      feed_format_type phase_plan[8];
      bit              burst;
      phase_plan = '{FMT_ALNUM, FMT_NUM21, FMT_MASKED, FMT_NONE,
                     FMT_ALNUM, FMT_MASKED, FMT_NUM21, FMT_ALNUM};
      burst = 1'b0;

      reset           = 1'b1;
      start           = 1'b0;
      req_security_id = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      // Reset is held high from the start and dropped at a falling edge, away from the rising edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats. The first group relies on the reset value of the feed format,
      // which is the numeric 21-bit one: both ends of the range, the first bit past it, the top bit and all ones.
      send_directed(64'h0);
      send_directed(64'h0000_0000_001F_FFFF);
      send_directed(64'h0000_0000_0020_0000);
      send_directed(64'h8000_0000_0000_0000);
      send_directed(64'hFFFF_FFFF_FFFF_FFFF);

      // Masked numeric: the full mask and bit 25 alone pass, a bit in the hole or above bit 29 fails.
      set_feed_format(FMT_MASKED);
      send_directed(64'h0000_0000_3E00_FFFF);
      send_directed(64'h0000_0000_0200_0000);
      send_directed(64'h0000_0000_0001_0000);
      send_directed(64'h0000_0000_4000_0000);

      // Alphanumeric symbols: lowest and highest packed values, a mix of all three
      // character classes, then a bad prefix and characters just outside each class.
      set_feed_format(FMT_ALNUM);
      send_directed({16'h0000, "000000"});
      send_directed({16'hFFFF, "03zzzz"});
      send_directed({16'h5AA5, "01AZa9"});
      send_directed({16'h0000, "04AAAA"});
      send_directed({16'h0000, "0/AAAA"});
      send_directed({16'h0000, "10AAAA"});
      send_directed({16'h0000, "02AAA:"});
      send_directed({16'h0000, "02AA@A"});
      send_directed({16'h0000, "02A[AA"});
      send_directed({16'h0000, "02`AAA"});
      send_directed({16'h0000, "02AAA{"});

      // Unsupported format rejects everything, a well-formed symbol included.
      set_feed_format(FMT_NONE);
      send_directed(64'hFFFF_FFFF_FFFF_FFFF);
      send_directed({16'h0000, "03zzzz"});

      // Random phases, one feed format each. Runs of back-to-back beats alternate with
      // random gaps so that idle cycles land on every stage of the pipeline.
      foreach (phase_plan[p]) begin
         set_feed_format(phase_plan[p]);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (i % 10 == 0) burst = ($urandom_range(0, 3) == 0);
            send_id(random_id(phase_plan[p]), burst ? 0 : $urandom_range(0, 12));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Checked %0d result beats (%0d directed): %0d numeric, %0d masked, %0d symbol,",
               sb.checked_count, directed_beats, beats_per_fmt[FMT_NUM21],
               beats_per_fmt[FMT_MASKED], beats_per_fmt[FMT_ALNUM]);
      $display("%0d unsupported; %0d identifiers passed; %0d feed format writes; %0d mismatches.",
               beats_per_fmt[FMT_NONE], sb.passed_count, format_writes, sb.error_count);
      if (sb.error_count == 0 && sb.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
